// ===== rtl/ahlp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ASCII hex line parser: constants, types and helper functions.
// Used by the interface file, the register block, the parser core and the top level.
package ahlp_pkg;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int SKIP_W  = 8;
    localparam int COUNT_W = 9;

    // largest line length in bytes
    localparam logic [COUNT_W-1:0] MAX_BYTES = 9'd256;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // nibble decode
    localparam logic [3:0] NIBBLE_MASK = 4'hf;
    localparam logic [4:0] NIBBLE_ADJ  = 5'd9;

    // register map: index taken from paddr bit 2
    localparam int APB_ADDR_W = 3;
    localparam logic REG_SKIP_LENGTH = 1'b0;
    localparam logic REG_CAPACITY    = 1'b1;

    // register reset values
    localparam logic [SKIP_W-1:0]  SKIP_LENGTH_RST = 8'd1;
    localparam logic [COUNT_W-1:0] CAPACITY_RST    = 9'd256;

    // settings seen by the core
    typedef struct packed {
        logic [SKIP_W-1:0]  skip_length;
        logic [COUNT_W-1:0] limit;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic               byte_valid;
        logic [CHAR_W-1:0]  data_byte;
        logic               line_done;
        logic [COUNT_W-1:0] parsed_count;
    } res_t;

    function automatic logic is_alnum(input logic [CHAR_W-1:0] ch);
        is_alnum = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5a) ||
                   (ch >= 8'h61 && ch <= 8'h7a);
    endfunction

    function automatic logic is_eol(input logic [CHAR_W-1:0] ch);
        is_eol = (ch == CHAR_LF) || (ch == CHAR_CR);
    endfunction

    function automatic logic [4:0] nibble_of(input logic [CHAR_W-1:0] ch);
        logic [4:0] low;
        low = {1'b0, ch[3:0] & NIBBLE_MASK};
        nibble_of = (ch > CHAR_NINE) ? low + NIBBLE_ADJ : low;
    endfunction

endpackage

// ===== rtl/ahlp_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the ASCII hex line parser: character input and result output.
// Depends on ahlp_pkg for the field widths.
interface ahlp_char_if
    import ahlp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface ahlp_res_if
    import ahlp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               byte_valid;
    logic [CHAR_W-1:0]  data_byte;
    logic               line_done;
    logic [COUNT_W-1:0] parsed_count;

    modport source (output valid, output byte_valid, output data_byte, output line_done,
                    output parsed_count, input ready);
    modport sink   (input valid, input byte_valid, input data_byte, input line_done,
                    input parsed_count, output ready);
endinterface

// ===== rtl/ahlp_cfg.sv =====
`timescale 1ns / 1ps
// APB register block of the ASCII hex line parser: skip length and capacity.
// Depends on ahlp_pkg; the clamped line limit is handed to the core.
module ahlp_cfg
    import ahlp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [SKIP_W-1:0]  skip_length_reg;
    logic [COUNT_W-1:0] capacity_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_length_reg <= SKIP_LENGTH_RST;
            capacity_reg    <= CAPACITY_RST;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_SKIP_LENGTH)
            begin
                skip_length_reg <= pwdata[SKIP_W-1:0];
            end
            else
            begin
                capacity_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_sel)
            REG_SKIP_LENGTH: prdata = {{(32-SKIP_W){1'b0}}, skip_length_reg};
            REG_CAPACITY:    prdata = {{(32-COUNT_W){1'b0}}, capacity_reg};
        endcase
    end

    // zero acts as one, anything above the maximum as the maximum
    always_comb
    begin
        cfg.skip_length = skip_length_reg;
        priority if (capacity_reg == '0)
        begin
            cfg.limit = {{(COUNT_W-1){1'b0}}, 1'b1};
        end
        else if (capacity_reg > MAX_BYTES)
        begin
            cfg.limit = MAX_BYTES;
        end
        else
        begin
            cfg.limit = capacity_reg;
        end
    end

endmodule

// ===== rtl/ahlp_core.sv =====
`timescale 1ns / 1ps
// Parser core: input register, per-character phase update and result register.
// Depends on ahlp_pkg and the channel interfaces in ahlp_if.
module ahlp_core
    import ahlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    ahlp_char_if.sink  in_ch,
    ahlp_res_if.source out_ch
);

    // phase codes
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_DROP   = 2'd3;

    // input stage
    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;

    // parse state
    logic [1:0]         phase_reg,      phase_next;
    logic [CHAR_W-1:0]  first_char_reg, first_char_next;
    logic [SKIP_W-1:0]  skip_left_reg,  skip_left_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               post_pair_reg,  post_pair_next;

    // result stage
    logic out_valid_reg;
    res_t out_res_reg;

    logic               has_res;
    res_t               res;
    logic               advance;
    logic [COUNT_W-1:0] count_inc;
    logic [4:0]         hi_nib;
    logic [4:0]         lo_nib;
    logic [CHAR_W-1:0]  pair_val;
    logic [CHAR_W-1:0]  ch;

    assign ch        = s1_char_reg;
    assign count_inc = byte_count_reg + 1'b1;
    assign hi_nib    = nibble_of(first_char_reg);
    assign lo_nib    = nibble_of(ch);
    assign pair_val  = is_alnum(first_char_reg) ?
                       ({hi_nib[3:0], 4'b0000} + {3'b000, lo_nib}) : '0;

    // the stored character moves on when its request has room or it gives none
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready || !has_res);
    assign in_ch.ready = !s1_valid_reg || advance;

    // phase update for one character
    always_comb
    begin
        phase_next      = phase_reg;
        first_char_next = first_char_reg;
        skip_left_next  = skip_left_reg;
        byte_count_next = byte_count_reg;
        post_pair_next  = post_pair_reg;
        has_res         = 1'b0;
        res.byte_valid   = 1'b0;
        res.data_byte    = '0;
        res.line_done    = 1'b1;
        res.parsed_count = byte_count_reg;

        unique case (phase_reg)
            PH_FIRST:
            begin
                if (ch == CHAR_NUL || is_eol(ch))
                begin
                    has_res         = 1'b1;
                    byte_count_next = '0;
                    post_pair_next  = 1'b0;
                    skip_left_next  = '0;
                end
                else if (ch != CHAR_SPACE)
                begin
                    first_char_next = ch;
                    phase_next      = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                has_res = 1'b1;
                if (ch == CHAR_NUL)
                begin
                    byte_count_next = '0;
                    phase_next      = PH_FIRST;
                    post_pair_next  = 1'b0;
                    skip_left_next  = '0;
                end
                else
                begin
                    res.byte_valid   = 1'b1;
                    res.data_byte    = pair_val;
                    res.parsed_count = count_inc;
                    if (count_inc >= cfg.limit)
                    begin
                        res.line_done   = 1'b1;
                        byte_count_next = '0;
                        phase_next      = PH_DROP;
                        post_pair_next  = 1'b0;
                        skip_left_next  = '0;
                    end
                    else
                    begin
                        res.line_done   = 1'b0;
                        byte_count_next = count_inc;
                        if (cfg.skip_length != '0)
                        begin
                            phase_next     = PH_SKIP;
                            skip_left_next = cfg.skip_length;
                            post_pair_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                if (ch == CHAR_NUL || (post_pair_reg && is_eol(ch)))
                begin
                    has_res         = 1'b1;
                    byte_count_next = '0;
                    phase_next      = PH_FIRST;
                    post_pair_next  = 1'b0;
                    skip_left_next  = '0;
                end
                else
                begin
                    post_pair_next = 1'b0;
                    if (skip_left_reg <= {{(SKIP_W-1){1'b0}}, 1'b1})
                    begin
                        skip_left_next = '0;
                        phase_next     = PH_FIRST;
                    end
                    else
                    begin
                        skip_left_next = skip_left_reg - 1'b1;
                    end
                end
            end
            PH_DROP:
            begin
                if (ch == CHAR_NUL || is_eol(ch))
                begin
                    phase_next = PH_FIRST;
                end
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_char_reg <= in_ch.char_code;
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            first_char_reg <= '0;
            skip_left_reg  <= '0;
            byte_count_reg <= '0;
            post_pair_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            first_char_reg <= first_char_next;
            skip_left_reg  <= skip_left_next;
            byte_count_reg <= byte_count_next;
            post_pair_reg  <= post_pair_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_res)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.byte_valid   = out_res_reg.byte_valid;
    assign out_ch.data_byte    = out_res_reg.data_byte;
    assign out_ch.line_done    = out_res_reg.line_done;
    assign out_ch.parsed_count = out_res_reg.parsed_count;

    // checks
    a_end_request_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.byte_valid |->
            out_res_reg.line_done && out_res_reg.data_byte == '0)
        else $error("line end request carries a byte");

    a_drop_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DROP |-> byte_count_reg == '0)
        else $error("count not cleared while dropping");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_left_reg != '0)
        else $error("skip phase with nothing left to skip");

    a_done_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_res && res.line_done |=> byte_count_reg == '0)
        else $error("count kept after line end");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_res |-> !out_valid_reg || out_ch.ready)
        else $error("pending request overwritten");

endmodule

// ===== rtl/ascii_hex_line_parser.sv =====
`timescale 1ns / 1ps
// ASCII hex line parser, top level: APB registers and parser core.
// An accepted character is held in the input register; its request then goes to the result register.
// Throughput: one character per cycle; the input register only holds while the
// result register is full, not taken, and the held character gives a request.
// Reset (rst_n, asynchronous, active low): skip length 1, capacity 256, empty line.
// Depends on ahlp_pkg, ahlp_if, ahlp_cfg and ahlp_core.
module ascii_hex_line_parser
    import ahlp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    ahlp_char_if.sink             in_ch,
    ahlp_res_if.source            out_ch
);

    cfg_t cfg;

    // register block
    ahlp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parser core
    ahlp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
